// File: hdl/dmc_pkg.sv
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared types and constants for the direct-mapped cache tag check block.
// ----------------------------------------------------------------------------
`default_nettype none

package dmc_pkg;

    localparam int ADDR_W     = 32;
    localparam int TAG_W      = 32;
    localparam int COUNT_W    = 32;
    localparam int LINE_OUT_W = 14;
    localparam int CFG_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int SPLIT_W    = 6;
    localparam int IB_W       = 5;

    // result word: hit, line_index, access_count, miss_count, one pad bit
    localparam int M_DATA_W   = 80;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;

    localparam logic [CFG_W-1:0] OFFSET_BITS_RST = 4'd4;
    localparam logic [CFG_W-1:0] INDEX_BITS_RST  = 4'd8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_COMPARE
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic capture;
        logic lookup;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// File: hdl/direct_mapped_cache_tag_check_top.sv
// ----------------------------------------------------------------------------
// direct_mapped_cache_tag_check_top
// Direct-mapped cache tag check with fill on miss and saturating counters.
// ----------------------------------------------------------------------------
// Each address is handled in order: the accepting cycle captures it, lookup
// does a registered read of the tag memory (one read port, one write port),
// and compare does the hit check and fill on miss and loads the result
// register. A new address is taken only once the previous one has left
// compare, which waits while the result register is held by m_tready. After
// reset a clearing pass walks the tag memory one line a cycle, during which
// s_tready stays low; configuration writes are taken at any time. The split
// uses offset_bits and index_bits, the latter clamped to the largest k with
// 2^k <= MAX_LINES.
`default_nettype none

module direct_mapped_cache_tag_check_top #(
    parameter int MAX_LINES = 16384
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // address
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [dmc_pkg::ADDR_W-1:0]     s_tdata,
    // hit, line_index[13:0], access_count[31:0], miss_count[31:0], zero pad
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [dmc_pkg::M_DATA_W-1:0]        m_tdata,
    // configuration writes
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [dmc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dmc_pkg::CFG_W-1:0]      cfg_data
);

    dmc_pkg::cmd_t    cmd;
    dmc_pkg::status_t status;

    assign cfg_ready = 1'b1;

    dmc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dmc_datapath #(
        .MAX_LINES (MAX_LINES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_addr    (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

// File: hdl/dmc_ctrl.sv
// ----------------------------------------------------------------------------
// dmc_ctrl
// Sequencer: tag memory clearing pass, then capture, lookup and compare/fill
// for one address at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire dmc_pkg::status_t status,
    output dmc_pkg::cmd_t        cmd
);

    dmc_pkg::state_t state_reg;
    dmc_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dmc_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dmc_pkg::ST_CLEAR: begin
                if (status.clear_last) state_next = dmc_pkg::ST_IDLE;
            end
            dmc_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = dmc_pkg::ST_LOOKUP;
            end
            dmc_pkg::ST_LOOKUP: begin
                state_next = dmc_pkg::ST_COMPARE;
            end
            dmc_pkg::ST_COMPARE: begin
                // hold until the result register can take the new result
                if (status.out_free) state_next = dmc_pkg::ST_IDLE;
            end
            default: begin
                state_next = dmc_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        s_tready       = 1'b0;
        cmd.clear_step = 1'b0;
        cmd.capture    = 1'b0;
        cmd.lookup     = 1'b0;
        cmd.commit     = 1'b0;
        unique case (state_reg)
            dmc_pkg::ST_CLEAR: begin
                cmd.clear_step = 1'b1;
            end
            dmc_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            dmc_pkg::ST_LOOKUP: begin
                cmd.lookup = 1'b1;
            end
            dmc_pkg::ST_COMPARE: begin
                cmd.commit = status.out_free;
            end
            default: begin
                cmd.clear_step = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/dmc_datapath.sv
// ----------------------------------------------------------------------------
// dmc_datapath
// Address split, tag memory with valid bit, hit compare, saturating counters,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_datapath #(
    parameter int MAX_LINES = 16384
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire dmc_pkg::cmd_t                  cmd,
    output dmc_pkg::status_t                    status,
    input  wire logic [dmc_pkg::ADDR_W-1:0]     s_addr,
    input  wire logic                           cfg_valid,
    input  wire logic [dmc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dmc_pkg::CFG_W-1:0]      cfg_data,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [dmc_pkg::M_DATA_W-1:0]        m_tdata
);

    localparam int LINE_W  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    // largest k with 2^k <= MAX_LINES
    localparam int IDX_CAP = $clog2(MAX_LINES + 1) - 1;
    localparam logic [dmc_pkg::IB_W-1:0] IDX_CAP_V = dmc_pkg::IB_W'(IDX_CAP);
    localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(MAX_LINES - 1);
    localparam int MEM_W = dmc_pkg::TAG_W + 1;

    // configuration
    logic [dmc_pkg::CFG_W-1:0] offset_bits_reg;
    logic [dmc_pkg::CFG_W-1:0] index_bits_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_bits_reg <= dmc_pkg::OFFSET_BITS_RST;
            index_bits_reg  <= dmc_pkg::INDEX_BITS_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                dmc_pkg::REG_OFFSET_BITS: begin
                    offset_bits_reg <= cfg_data;
                end
                dmc_pkg::REG_INDEX_BITS: begin
                    index_bits_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // captured address
    logic [dmc_pkg::ADDR_W-1:0] addr_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) addr_reg <= s_addr;
    end

    // address split
    logic [dmc_pkg::IB_W-1:0]    ib_eff;
    logic [dmc_pkg::SPLIT_W-1:0] split;
    logic [dmc_pkg::ADDR_W:0]    line_mask;
    logic [dmc_pkg::ADDR_W-1:0]  shifted;
    logic [dmc_pkg::ADDR_W-1:0]  line_full;
    logic [dmc_pkg::TAG_W-1:0]   tag_calc;

    always_comb begin
        ib_eff = ({1'b0, index_bits_reg} > IDX_CAP_V) ? IDX_CAP_V
                                                        : {1'b0, index_bits_reg};
        split     = dmc_pkg::SPLIT_W'(offset_bits_reg) + dmc_pkg::SPLIT_W'(ib_eff);
        line_mask = ((dmc_pkg::ADDR_W+1)'(1) << ib_eff) - (dmc_pkg::ADDR_W+1)'(1);
        shifted   = addr_reg >> offset_bits_reg;
        line_full = shifted & line_mask[dmc_pkg::ADDR_W-1:0];
        tag_calc  = (split >= dmc_pkg::SPLIT_W'(32)) ? '0 : (addr_reg >> split);
    end

    logic [LINE_W-1:0]                 line_reg;
    logic [dmc_pkg::LINE_OUT_W-1:0]    line_out_reg;
    logic [dmc_pkg::TAG_W-1:0]         tag_reg;

    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            line_reg     <= line_full[LINE_W-1:0];
            line_out_reg <= line_full[dmc_pkg::LINE_OUT_W-1:0];
            tag_reg      <= tag_calc;
        end
    end

    // clearing pass counter
    logic [LINE_W-1:0] clear_cnt_reg;
    logic [LINE_W-1:0] clear_cnt_next;

    always_comb begin
        clear_cnt_next = clear_cnt_reg;
        if (cmd.clear_step) clear_cnt_next = clear_cnt_reg + LINE_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_cnt_reg <= '0;
        end else begin
            clear_cnt_reg <= clear_cnt_next;
        end
    end

    // tag memory: valid bit on top of the stored tag
    logic [MEM_W-1:0]  tag_mem [MAX_LINES];
    logic [MEM_W-1:0]  rd_data_reg;
    logic              hit;
    logic              mem_we;
    logic [LINE_W-1:0] mem_wa;
    logic [MEM_W-1:0]  mem_wd;

    assign hit    = rd_data_reg[MEM_W-1] && (rd_data_reg[dmc_pkg::TAG_W-1:0] == tag_reg);
    assign mem_we = cmd.clear_step || (cmd.commit && !hit);
    assign mem_wa = cmd.clear_step ? clear_cnt_reg : line_reg;
    assign mem_wd = cmd.clear_step ? '0 : {1'b1, tag_reg};

    always_ff @(posedge aclk) begin
        if (mem_we) tag_mem[mem_wa] <= mem_wd;
        rd_data_reg <= tag_mem[line_full[LINE_W-1:0]];
    end

    // saturating counters
    logic [dmc_pkg::COUNT_W-1:0] access_cnt_reg;
    logic [dmc_pkg::COUNT_W-1:0] access_cnt_next;
    logic [dmc_pkg::COUNT_W-1:0] miss_cnt_reg;
    logic [dmc_pkg::COUNT_W-1:0] miss_cnt_next;

    always_comb begin
        access_cnt_next = access_cnt_reg;
        miss_cnt_next   = miss_cnt_reg;
        if (cmd.commit) begin
            if (access_cnt_reg != dmc_pkg::COUNT_MAX) begin
                access_cnt_next = access_cnt_reg + dmc_pkg::COUNT_W'(1);
            end
            if (!hit && (miss_cnt_reg != dmc_pkg::COUNT_MAX)) begin
                miss_cnt_next = miss_cnt_reg + dmc_pkg::COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            access_cnt_reg <= '0;
            miss_cnt_reg   <= '0;
        end else begin
            access_cnt_reg <= access_cnt_next;
            miss_cnt_reg   <= miss_cnt_next;
        end
    end

    // result register
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic                            out_hit_reg;
    logic [dmc_pkg::LINE_OUT_W-1:0]  out_line_reg;
    logic [dmc_pkg::COUNT_W-1:0]     out_access_reg;
    logic [dmc_pkg::COUNT_W-1:0]     out_miss_reg;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_hit_reg    <= hit;
            out_line_reg   <= line_out_reg;
            out_access_reg <= access_cnt_next;
            out_miss_reg   <= miss_cnt_next;
        end
    end

    assign status.clear_last = cmd.clear_step && (clear_cnt_reg == LAST_LINE);
    assign status.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_miss_reg, out_access_reg, out_line_reg, out_hit_reg};

endmodule

`default_nettype wire
